// File: src/tksrb_pkg.sv
// package for the time key sort and release buffer
// holds sizes, command record, back-end states; no dependencies
package tksrb_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned BASE_W   = 16;
  localparam int unsigned TAG_W    = 64;
  localparam int unsigned QDEPTH   = 2;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic {
    ST_EMITTED  = 1'b0,
    ST_REJECTED = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RELEASE,
    S_FLUSH
  } back_state_e;

  typedef struct packed {
    logic              operation;
    logic [TIME_W-1:0] record_time;
    logic [BASE_W-1:0] record_baseline;
    logic [TAG_W-1:0]  record_tag;
    logic [TIME_W-1:0] release_cutoff;
  } cmd_t;

endpackage

// File: src/tksrb_if.sv
// handshake channels for the sort buffer input and result streams
// depends on tksrb_pkg
interface tksrb_in_if import tksrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TIME_W-1:0] record_time;
  logic [BASE_W-1:0] record_baseline;
  logic [TAG_W-1:0]  record_tag;
  logic [TIME_W-1:0] release_cutoff;

  modport source (output valid, operation, record_time, record_baseline, record_tag,
                  release_cutoff, input ready);
  modport sink   (input valid, operation, record_time, record_baseline, record_tag,
                  release_cutoff, output ready);
endinterface

interface tksrb_out_if import tksrb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] out_time;
  logic [BASE_W-1:0] out_baseline;
  logic [TAG_W-1:0]  out_tag;
  logic              last_of_run;
  logic              status;

  modport source (output valid, out_time, out_baseline, out_tag, last_of_run, status,
                  input ready);
  modport sink   (input valid, out_time, out_baseline, out_tag, last_of_run, status,
                  output ready);
endinterface

// File: src/tksrb_front.sv
// front end: accepts input transfers into a short command queue
// depends on tksrb_pkg and tksrb_in_if
module tksrb_front import tksrb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  tksrb_in_if.sink      in_i,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  logic          cmd_pop_i
);

  localparam int unsigned PW = $clog2(QDEPTH);

  cmd_t          slot_q [QDEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   fill_q, fill_d;
  logic          push, pop;

  assign in_i.ready  = (fill_q != (PW+1)'(QDEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (fill_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_q];

  // pointer and fill update
  always_comb begin
    wr_d   = push ? wr_q + PW'(1) : wr_q;
    rd_d   = pop  ? rd_q + PW'(1) : rd_q;
    fill_d = fill_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= '{operation: in_i.operation, record_time: in_i.record_time,
                        record_baseline: in_i.record_baseline,
                        record_tag: in_i.record_tag,
                        release_cutoff: in_i.release_cutoff};
    end
  end

endmodule

// File: src/tksrb_back.sv
// back end: sorted insertion line, release and flush sequencer, result register
// depends on tksrb_pkg and tksrb_out_if
module tksrb_back import tksrb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output logic          cmd_pop_o,
  tksrb_out_if.source   out_o
);

  logic [TIME_W-1:0] time_q [CAPACITY];
  logic [BASE_W-1:0] base_q [CAPACITY];
  logic [TAG_W-1:0]  tag_q  [CAPACITY];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [TIME_W-1:0] cutoff_q;
  back_state_e       state_q, state_d;

  logic              ovalid_q;
  logic [TIME_W-1:0] otime_q;
  logic [BASE_W-1:0] obase_q;
  logic [TAG_W-1:0]  otag_q;
  logic              olast_q, ostat_q;

  logic out_free, emit, emit_last, emit_reject, do_insert, do_shift;
  logic front_rel, next_rel;
  logic [CAPACITY-1:0] le;

  assign out_free  = !ovalid_q || out_o.ready;
  assign front_rel = (count_q != '0) && (time_q[0] <= cutoff_q);
  assign next_rel  = (count_q > CNT_W'(1)) && (time_q[1] <= cutoff_q);

  // per-entry compare: held entry sorts at or before the new record
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (CNT_W'(i) < count_q) &&
              ({time_q[i], base_q[i]} <= {cmd_i.record_time, cmd_i.record_baseline});
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.operation == OP_FLUSH) begin
            if (count_q != '0) state_d = S_FLUSH;
          end else if (count_q == CNT_W'(CAPACITY - 1)) begin
            state_d = S_RELEASE;
          end
        end
      end
      S_RELEASE: begin
        if (!front_rel) state_d = S_IDLE;
        else if (out_free && !next_rel) state_d = S_IDLE;
      end
      S_FLUSH: begin
        if (out_free && count_q == CNT_W'(1)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // actions
  always_comb begin
    cmd_pop_o   = 1'b0;
    emit        = 1'b0;
    emit_last   = 1'b0;
    emit_reject = 1'b0;
    do_insert   = 1'b0;
    do_shift    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.operation == OP_FLUSH) begin
            cmd_pop_o = 1'b1;
          end else if (count_q == CNT_W'(CAPACITY)) begin
            if (out_free) begin
              cmd_pop_o   = 1'b1;
              emit        = 1'b1;
              emit_last   = 1'b1;
              emit_reject = 1'b1;
            end
          end else begin
            cmd_pop_o = 1'b1;
            do_insert = 1'b1;
          end
        end
      end
      S_RELEASE: begin
        if (front_rel && out_free) begin
          emit      = 1'b1;
          emit_last = !next_rel;
          do_shift  = 1'b1;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = (count_q == CNT_W'(1));
          do_shift  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_insert) count_d = count_q + CNT_W'(1);
    else if (do_shift) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (emit) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  // insertion line: new record lands after all entries with key not above it
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      cutoff_q <= cmd_i.release_cutoff;
      for (int i = 0; i < CAPACITY; i++) begin
        if (!le[i]) begin
          if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
            time_q[i] <= cmd_i.record_time;
            base_q[i] <= cmd_i.record_baseline;
            tag_q[i]  <= cmd_i.record_tag;
          end else begin
            time_q[i] <= time_q[(i == 0) ? 0 : i-1];
            base_q[i] <= base_q[(i == 0) ? 0 : i-1];
            tag_q[i]  <= tag_q[(i == 0) ? 0 : i-1];
          end
        end
      end
    end else if (do_shift) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        time_q[i] <= time_q[i+1];
        base_q[i] <= base_q[i+1];
        tag_q[i]  <= tag_q[i+1];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      otime_q <= emit_reject ? '0 : time_q[0];
      obase_q <= emit_reject ? '0 : base_q[0];
      otag_q  <= emit_reject ? '0 : tag_q[0];
      olast_q <= emit_last;
      ostat_q <= emit_reject ? ST_REJECTED : ST_EMITTED;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.out_time     = otime_q;
  assign out_o.out_baseline = obase_q;
  assign out_o.out_tag      = otag_q;
  assign out_o.last_of_run  = olast_q;
  assign out_o.status       = ostat_q;

endmodule

// File: src/time_key_sort_release_buffer.sv
// time key sort buffer: the back end takes each add or flush command in its idle state,
// then emits results; a filling add that releases nothing still enters the release state.
// a rejected add passes the command queue and the result register; a flush or a releasing
// add also passes the flush or release state; results wait while busy or output stalls.
// insertion line sorts the store; release, flush shift one entry a cycle unless stalled.
// reset empties the store and queue; stored data is not cleared.
module time_key_sort_release_buffer import tksrb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tksrb_in_if.sink    in_i,
  tksrb_out_if.source out_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // front end and command queue
  tksrb_front u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // sorted store and result sequencer
  tksrb_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_o
  );

endmodule

// File: src/tksrb_checker.sv
// port-level checks for the sort buffer result stream
// depends on tksrb_pkg; bound to time_key_sort_release_buffer
module tksrb_checker import tksrb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_i,
  input logic              ready_i,
  input logic [TIME_W-1:0] time_i,
  input logic [BASE_W-1:0] base_i,
  input logic [TAG_W-1:0]  tag_i,
  input logic              last_i,
  input logic              status_i
);

  // stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i) else $error("result dropped while stalled");

  // stalled result keeps its time and tag
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable(time_i) && $stable(tag_i))
    else $error("result changed while stalled");

  // a rejection carries zero fields
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i |-> time_i == '0 && base_i == '0 && tag_i == '0)
    else $error("rejection with nonzero fields");

  // a rejection ends its run
  a_rej_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i |-> last_i) else $error("rejection not last of run");

endmodule

bind time_key_sort_release_buffer tksrb_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_i  (out_o.valid),
  .ready_i  (out_o.ready),
  .time_i   (out_o.out_time),
  .base_i   (out_o.out_baseline),
  .tag_i    (out_o.out_tag),
  .last_i   (out_o.last_of_run),
  .status_i (out_o.status)
);

// File: bench/tksrb_tb_if.sv
`timescale 1ns / 100ps
// testbench package: result record shared by the predictor and the result checker
// depends on tksrb_pkg
package tksrb_tb_pkg;
  import tksrb_pkg::*;

  // one expected or observed result record
  typedef struct packed {
    logic [TIME_W-1:0] rtime;
    logic [BASE_W-1:0] rbase;
    logic [TAG_W-1:0]  rtag;
    logic              last;
    status_e           status;
  } emit_t;
endpackage

// File: bench/tb.sv
`timescale 1ns / 100ps
// testbench for time_key_sort_release_buffer: directed, fill, stall, random adds/flushes
// depends on tksrb_pkg, tksrb_if and tksrb_tb_pkg; results checked against a sorting predictor
module tb;
  import tksrb_pkg::*;
  import tksrb_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_ITEMS  = 25;

  typedef struct {
    op_e               op;
    logic [TIME_W-1:0] rtime;
    logic [BASE_W-1:0] rbase;
    logic [TAG_W-1:0]  rtag;
    logic [TIME_W-1:0] cutoff;
  } rec_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tksrb_in_if  in_ch();
  tksrb_out_if out_ch();

  time_key_sort_release_buffer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: sorted-on-demand copy of the store
  logic [TIME_W-1:0] held_time[$];
  logic [BASE_W-1:0] held_base[$];
  logic [TAG_W-1:0]  held_tag[$];
  emit_t             pending_emits[$];

  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned sent_count   = 0;
  int unsigned got_count    = 0;
  int unsigned reject_count = 0;
  int unsigned release_runs = 0;
  int unsigned flush_runs   = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_until   = 0;

  // stable insertion sort by time then baseline
  task automatic order_store();
    int j;
    logic [TIME_W-1:0] t;
    logic [BASE_W-1:0] b;
    logic [TAG_W-1:0]  g;
    for (int i = 1; i < held_time.size(); i++) begin
      t = held_time[i]; b = held_base[i]; g = held_tag[i];
      j = i;
      while (j > 0 && (held_time[j-1] > t || (held_time[j-1] == t && held_base[j-1] > b))) begin
        held_time[j] = held_time[j-1];
        held_base[j] = held_base[j-1];
        held_tag[j]  = held_tag[j-1];
        j--;
      end
      held_time[j] = t; held_base[j] = b; held_tag[j] = g;
    end
  endtask

  task automatic emit_front(int n);
    emit_t e;
    for (int k = 0; k < n; k++) begin
      e.rtime = held_time.pop_front();
      e.rbase = held_base.pop_front();
      e.rtag  = held_tag.pop_front();
      e.last  = (k == n - 1);
      e.status = ST_EMITTED;
      pending_emits.push_back(e);
    end
  endtask

  // predict the results caused by one accepted command
  task automatic predict_sort(rec_cmd_t c);
    emit_t e;
    int rel;
    if (c.op == OP_FLUSH) begin
      order_store();
      if (held_time.size() > 0) flush_runs++;
      emit_front(held_time.size());
    end else if (held_time.size() >= CAPACITY) begin
      e = '0;
      e.last = 1'b1;
      e.status = ST_REJECTED;
      pending_emits.push_back(e);
      reject_count++;
    end else begin
      held_time.push_back(c.rtime);
      held_base.push_back(c.rbase);
      held_tag.push_back(c.rtag);
      if (held_time.size() == CAPACITY) begin
        order_store();
        rel = 0;
        while (rel < held_time.size() && held_time[rel] <= c.cutoff) rel++;
        if (rel > 0) release_runs++;
        emit_front(rel);
      end
    end
  endtask

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // result checker at the rising edge
  always @(posedge clk_i) begin
    emit_t exp_e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_count++;
      if (pending_emits.size() == 0) begin
        $error("unexpected result time=%h status=%b", out_ch.out_time, out_ch.status);
        fail_count++;
      end else begin
        exp_e = pending_emits.pop_front();
        if (out_ch.out_time !== exp_e.rtime) begin
          $error("out_time expected %h got %h", exp_e.rtime, out_ch.out_time);
          fail_count++;
        end
        if (out_ch.out_baseline !== exp_e.rbase) begin
          $error("out_baseline expected %h got %h", exp_e.rbase, out_ch.out_baseline);
          fail_count++;
        end
        if (out_ch.out_tag !== exp_e.rtag) begin
          $error("out_tag expected %h got %h", exp_e.rtag, out_ch.out_tag);
          fail_count++;
        end
        if (out_ch.last_of_run !== exp_e.last) begin
          $error("last_of_run expected %b got %b", exp_e.last, out_ch.last_of_run);
          fail_count++;
        end
        if (out_ch.status !== exp_e.status) begin
          $error("status expected %b got %b", exp_e.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  // receiver readiness, updated at the falling edge; held low until hold_until
  always @(negedge clk_i) begin
    if (cycle_count < hold_until) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // offer one command and wait for its transfer; valid stays up for the next one
  task automatic send_cmd(rec_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= c.op;
    in_ch.record_time     <= c.rtime;
    in_ch.record_baseline <= c.rbase;
    in_ch.record_tag      <= c.rtag;
    in_ch.release_cutoff  <= c.cutoff;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_sort(c);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_emits.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  function automatic rec_cmd_t rand_add(bit narrow);
    rec_cmd_t c;
    c.op     = OP_ADD;
    c.rtime  = narrow ? TIME_W'($urandom_range(40)) : $urandom;
    c.rbase  = narrow ? BASE_W'($urandom_range(3)) : BASE_W'($urandom);
    c.rtag   = {$urandom, $urandom};
    c.cutoff = ($urandom_range(3) == 0) ? $urandom :
               (narrow ? TIME_W'($urandom_range(45)) : $urandom);
    return c;
  endfunction

  // fill the store to one short of capacity with random content
  task automatic top_up();
    while (held_time.size() < CAPACITY - 1) send_cmd(rand_add(1'($urandom_range(1))));
  endtask

  rec_cmd_t dir_rows[$];
  rec_cmd_t c;
  int unsigned rand_goal;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ADD;
    in_ch.record_time = '0;
    in_ch.record_baseline = '0;
    in_ch.record_tag = '0;
    in_ch.release_cutoff = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // sender idles 37 percent of the time, receiver 72 percent
    src_idle_pct = 37; snk_idle_pct = 72;

    // directed table: empty flush, extremes, equal keys, flush
    dir_rows.push_back('{OP_FLUSH, '0, '0, '0, '0});
    dir_rows.push_back('{OP_ADD, '1, '1, '1, '1});
    dir_rows.push_back('{OP_ADD, '0, '0, '0, '0});
    dir_rows.push_back('{OP_ADD, 32'd7, 16'd2, 64'hA, '0});
    dir_rows.push_back('{OP_ADD, 32'd7, 16'd2, 64'hB, '0});
    dir_rows.push_back('{OP_ADD, 32'd7, 16'd1, 64'hC, '0});
    dir_rows.push_back('{OP_ADD, 32'h8000_0000, 16'h8000, 64'h8000_0000_0000_0000, '0});
    dir_rows.push_back('{OP_FLUSH, '1, '1, '1, '1});
    foreach (dir_rows[i]) send_cmd(dir_rows[i]);
    wait_drained();

    // fill with cutoff zero: full store, only time-zero entries go; if none, next add rejected
    top_up();
    send_cmd('{OP_ADD, 32'd50, 16'd0, 64'h1, 32'd0});
    send_cmd('{OP_ADD, '1, '1, '1, '1});
    wait_drained();

    // roles swapped: sender idles 72 percent of the time, receiver 37 percent
    src_idle_pct = 72; snk_idle_pct = 37;

    // long receiver stall: a full-store flush backs up while adds keep coming
    hold_until = cycle_count + HOLD_CYCLES;
    send_cmd('{OP_FLUSH, '0, '0, '0, '0});
    for (int k = 0; k < 4; k++) send_cmd(rand_add(1'b1));
    // sender pauses until everything has come
    wait_drained();

    // refill and release the part at or below a mid-range cutoff
    top_up();
    send_cmd('{OP_ADD, 32'd20, 16'd1, 64'h7, 32'd20});
    wait_drained();

    // neither side idles: random adds and flushes
    src_idle_pct = 0; snk_idle_pct = 0;
    rand_goal = sent_count + RAND_ITEMS;
    while (sent_count < rand_goal) begin
      if ($urandom_range(4) == 0) c = '{OP_FLUSH, $urandom, '0, '0, $urandom};
      else c = rand_add(1'($urandom_range(1)));
      send_cmd(c);
    end
    wait_drained();

    send_cmd('{OP_FLUSH, '0, '0, '0, '0});
    wait_drained();

    $display("sent %0d commands, checked %0d results", sent_count, got_count);
    $display("release bursts %0d, flushes %0d, rejected adds %0d",
             release_runs, flush_runs, reject_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
